FILE: hdl/command_frame_parser_top_defines.svh
// Assertion macros shared by the command frame parser checker.
`ifndef COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/cfp_pkg.sv
// Types and constants of the command frame parser.
package cfp_pkg;

	// One input item: a received byte or a resync request.
	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} cfp_in_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic [7:0]  command_id;
		logic [7:0]  payload_len;
		logic [15:0] error_total;
	} cfp_out_t;

	// Input kinds.
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_RESYNC = 1'b1;

	// Result events.
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_BYTE  = 2'd1;
	localparam logic [1:0] EV_GOOD  = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	// Parser phases.
	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_MARKER  = 3'd1;
	localparam logic [2:0] PH_ID      = 3'd2;
	localparam logic [2:0] PH_LEN     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_SUM     = 3'd5;

	// Configuration register indexes and reset values.
	localparam logic       REG_START_MARKER = 1'b0;
	localparam logic       REG_MAX_LEN      = 1'b1;
	localparam logic [7:0] START_MARKER_RST = 8'h3E;
	localparam logic [7:0] MAX_LEN_RST      = 8'hFF;

endpackage

FILE: hdl/command_frame_parser_top.sv
// Command frame parser: deframes received bytes and checks both checksums.
//
// Input channel (item_valid, item_stall, item): one transfer per received byte,
// or a resync item that sends the parser back to hunting for a start marker.
// Output channel (result_valid, result_stall, result): exactly one result per
// input item, in order: nothing, a payload byte with its index, frame good, or
// protocol error, together with the current command id, declared length and
// the wrapping 16-bit error count.
// Configuration: cfg_en writes cfg_data into register cfg_index (0 start
// marker, 1 largest payload length); write only while the parser is idle.
// An input transfer is captured in the input register and, once the result
// register is free, passes through the parse logic into the result register.
// Throughput is one item per cycle while the receiver does not stall.
// While the receiver stalls, the result register holds and one further item
// waits in the input register; only then is item_stall raised.
// Reset clears the phase to hunting, the frame fields, the error count and
// both registers' valid flags, and loads the configuration reset values.
module command_frame_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cfp_pkg::cfp_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output cfp_pkg::cfp_out_t result,
	input  logic              cfg_en,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);
	import cfp_pkg::*;

	logic [7:0] marker_q;
	logic [7:0] max_len_q;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  frame_id_q, frame_id_d;
	logic [7:0]  frame_len_q, frame_len_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] err_q, err_d;

	logic        item_valid_s1;
	cfp_in_t     item_s1;
	logic        result_valid_s2;
	cfp_out_t    result_s2;

	logic        accept;
	logic        advance;
	logic [1:0]  ev;
	logic [7:0]  pbyte;
	logic [7:0]  pidx;
	logic [7:0]  hdr_check;

	// Handshake: the input register moves on when the result register is free.
	assign advance    = item_valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q  <= START_MARKER_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_en) begin
			if (cfg_index == REG_START_MARKER) begin
				marker_q <= cfg_data;
			end else begin
				max_len_q <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= accept || (item_valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Phase update and event for the item in the input register.
	assign hdr_check = frame_id_q + frame_len_q;

	always_comb begin
		phase_d     = phase_q;
		frame_id_d  = frame_id_q;
		frame_len_d = frame_len_q;
		count_d     = count_q;
		sum_d       = sum_q;
		ev          = EV_NONE;
		pbyte       = 8'd0;
		pidx        = 8'd0;
		if (item_s1.kind == KIND_RESYNC) begin
			phase_d = PH_HUNT;
		end else begin
			case (phase_q)
				PH_MARKER: begin
					frame_id_d = item_s1.rx_byte;
					count_d    = 8'd0;
					phase_d    = PH_ID;
				end
				PH_ID: begin
					frame_len_d = item_s1.rx_byte;
					phase_d     = PH_LEN;
				end
				PH_LEN: begin
					if (item_s1.rx_byte == hdr_check && frame_len_q <= max_len_q) begin
						sum_d   = 8'd0;
						count_d = 8'd0;
						phase_d = (frame_len_q == 8'd0) ? PH_SUM : PH_PAYLOAD;
					end else begin
						ev      = EV_ERROR;
						phase_d = PH_HUNT;
					end
				end
				PH_PAYLOAD: begin
					ev      = EV_BYTE;
					pbyte   = item_s1.rx_byte;
					pidx    = count_q;
					sum_d   = sum_q + item_s1.rx_byte;
					count_d = count_q + 8'd1;
					if (count_d == frame_len_q) begin
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					phase_d = PH_HUNT;
					ev      = (item_s1.rx_byte == sum_q) ? EV_GOOD : EV_ERROR;
				end
				default: begin
					if (item_s1.rx_byte == marker_q) begin
						phase_d = PH_MARKER;
					end else begin
						ev      = EV_ERROR;
						phase_d = PH_HUNT;
					end
				end
			endcase
		end
	end

	// Every protocol error counts once; the counter wraps.
	assign err_d = (ev == EV_ERROR) ? err_q + 16'd1 : err_q;

	// Parser state, updated when the item moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			frame_id_q  <= 8'd0;
			frame_len_q <= 8'd0;
			count_q     <= 8'd0;
			sum_q       <= 8'd0;
			err_q       <= 16'd0;
		end else if (advance) begin
			phase_q     <= phase_d;
			frame_id_q  <= frame_id_d;
			frame_len_q <= frame_len_d;
			count_q     <= count_d;
			sum_q       <= sum_d;
			err_q       <= err_d;
		end
	end

	// Result register: holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.event_res    <= ev;
			result_s2.payload_byte <= pbyte;
			result_s2.byte_index   <= pidx;
			result_s2.command_id   <= frame_id_d;
			result_s2.payload_len  <= frame_len_d;
			result_s2.error_total  <= err_d;
		end
	end

endmodule

FILE: hdl/cfp_checker.sv
// Port-level checker for the command frame parser, bound to the top level.
`include "command_frame_parser_top_defines.svh"

module cfp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input cfp_pkg::cfp_out_t result
);
	import cfp_pkg::*;

	logic        seen_q;
	logic [15:0] total_q;
	logic        res_xfer;
	logic [15:0] total_exp;

	assign res_xfer  = result_valid && !result_stall;
	assign total_exp = (result.event_res == EV_ERROR) ? total_q + 16'd1 : total_q;

	// Error count carried by the last result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			total_q <= 16'd0;
		end else if (res_xfer) begin
			seen_q  <= 1'b1;
			total_q <= result.error_total;
		end
	end

	// A stalled result stays offered.
	`CFP_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid,
		"result withdrawn while stalled")

	// The error count moves by one exactly on an error result.
	`CFP_ASSERT_NOW(a_error_count, res_xfer && seen_q, result.error_total == total_exp,
		"error count out of step with error results")

	// Payload fields are zero unless a payload byte is reported.
	`CFP_ASSERT_NOW(a_payload_zero, result_valid && result.event_res != EV_BYTE,
		result.payload_byte == 8'd0 && result.byte_index == 8'd0,
		"payload fields set without a payload byte")

	// A payload byte always lies inside the declared length.
	`CFP_ASSERT_NOW(a_index_range, result_valid && result.event_res == EV_BYTE,
		result.byte_index < result.payload_len,
		"payload byte index beyond declared length")

endmodule

bind command_frame_parser_top cfp_checker u_cfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
